@@ src/slm_pkg.sv @@
`default_nettype none

package slm_pkg;

   localparam logic [1:0] OP_SWAP_OUT = 2'd0;
   localparam logic [1:0] OP_SWAP_IN  = 2'd1;
   localparam logic [1:0] OP_CLEAN    = 2'd2;

   localparam logic [1:0] STATUS_OK      = 2'd0;
   localparam logic [1:0] STATUS_FULL    = 2'd1;
   localparam logic [1:0] STATUS_MISSING = 2'd2;

   localparam int SPACE_W  = 8;
   localparam int VADDR_W  = 32;
   localparam int INDEX_W  = 8;
   localparam int OFFSET_W = 20;

   typedef struct packed {
      logic               valid;
      logic [SPACE_W-1:0] space;
      logic [VADDR_W-1:0] vaddr;
   } slm_entry_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_POST
   } slm_state_type;

endpackage

`default_nettype wire

@@ src/slm_cell.sv @@
`default_nettype none

module slm_cell (
   input  wire                    clock,
   input  wire                    reset,
   input  wire                    shift_en,
   input  slm_pkg::slm_entry_type entry_d,
   output slm_pkg::slm_entry_type entry_q
);

   logic                        valid_ff;
   logic                        valid_in;
   logic [slm_pkg::SPACE_W-1:0] space_ff;
   logic [slm_pkg::VADDR_W-1:0] vaddr_ff;

   assign valid_in = shift_en ? entry_d.valid : valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (shift_en) begin
         space_ff <= entry_d.space;
         vaddr_ff <= entry_d.vaddr;
      end
   end

   assign entry_q.valid = valid_ff;
   assign entry_q.space = space_ff;
   assign entry_q.vaddr = vaddr_ff;

endmodule

`default_nettype wire

@@ src/swap_slot_map_top.sv @@
`default_nettype none

// channel | ports                                           | dir
// req     | req_valid req_stall req_opcode req_space_id     | in
//         | req_virt_addr                                   |
// rsp     | rsp_valid rsp_stall rsp_slot_index              | out
//         | rsp_swap_offset rsp_status                      |
//
// each request runs through an accept step, a full rotation of the slot ring
// past its head cell, and a step that loads the result
// the next request is taken while an earlier result still waits on rsp
// reset clears every valid mark at once; the ring holds still while idle
// a stalled result holds the scan controller in its final state

module swap_slot_map_top #(
   parameter int SLOT_COUNT = 256,
   parameter int PAGE_BYTES = 4096
) (
   input  wire                            clock,
   input  wire                            reset,
   input  wire                            req_valid,
   output logic                           req_stall,
   input  wire  [1:0]                     req_opcode,
   input  wire  [slm_pkg::SPACE_W-1:0]    req_space_id,
   input  wire  [slm_pkg::VADDR_W-1:0]    req_virt_addr,
   output logic                           rsp_valid,
   input  wire                            rsp_stall,
   output logic [slm_pkg::INDEX_W-1:0]    rsp_slot_index,
   output logic [slm_pkg::OFFSET_W-1:0]   rsp_swap_offset,
   output logic [1:0]                     rsp_status
);

   localparam int IDX_W  = $clog2(SLOT_COUNT);
   localparam int PROD_W = IDX_W + 20;
   localparam logic [IDX_W-1:0]  LAST_IDX    = IDX_W'(SLOT_COUNT - 1);
   localparam logic [PROD_W-1:0] PAGE_STRIDE = PROD_W'(PAGE_BYTES);

   slm_pkg::slm_entry_type ring_q [SLOT_COUNT];
   slm_pkg::slm_entry_type ring_d [SLOT_COUNT];
   slm_pkg::slm_entry_type head_new;

   slm_pkg::slm_state_type state_ff, state_in;

   logic [IDX_W-1:0]            cnt_ff, cnt_in;
   logic [1:0]                  op_ff;
   logic [slm_pkg::SPACE_W-1:0] sid_ff;
   logic [slm_pkg::VADDR_W-1:0] va_ff;
   logic                        found_ff, found_in;
   logic [IDX_W-1:0]            slot_ff, slot_in;
   logic                        shift_en;
   logic                        accept;
   logic                        rsp_load;
   logic                        hit;

   logic                          rsp_valid_ff, rsp_valid_in;
   logic [slm_pkg::INDEX_W-1:0]   rsp_slot_ff;
   logic [slm_pkg::OFFSET_W-1:0]  rsp_offset_ff;
   logic [1:0]                    rsp_status_ff;

   logic [PROD_W-1:0]   offset_prod;
   logic [IDX_W+7:0]    slot_ext;
   logic [1:0]          status_res;

   // ring of slot cells, head at position zero, tail fed from the head
   for (genvar k = 0; k < SLOT_COUNT; k++) begin : g_cell
      if (k == SLOT_COUNT - 1) begin : g_tail
         assign ring_d[k] = head_new;
      end else begin : g_mid
         assign ring_d[k] = ring_q[k+1];
      end
      slm_cell u_cell (
         .clock    (clock),
         .reset    (reset),
         .shift_en (shift_en),
         .entry_d  (ring_d[k]),
         .entry_q  (ring_q[k])
      );
   end

   assign accept = req_valid && !req_stall;

   // head cell update as the slot passes by
   always_comb begin
      head_new = ring_q[0];
      hit      = 1'b0;
      case (op_ff)
         slm_pkg::OP_SWAP_OUT: begin
            if (!found_ff && !ring_q[0].valid) begin
               head_new.valid = 1'b1;
               head_new.space = sid_ff;
               head_new.vaddr = va_ff;
               hit            = 1'b1;
            end
         end
         slm_pkg::OP_SWAP_IN: begin
            if (!found_ff && ring_q[0].valid && ring_q[0].space == sid_ff
                && ring_q[0].vaddr == va_ff) begin
               head_new.valid = 1'b0;
               hit            = 1'b1;
            end
         end
         slm_pkg::OP_CLEAN: begin
            if (ring_q[0].valid && ring_q[0].space == sid_ff) begin
               head_new.valid = 1'b0;
            end
         end
         default: begin
            head_new = ring_q[0];
         end
      endcase
   end

   always_comb begin
      state_in  = state_ff;
      cnt_in    = cnt_ff;
      found_in  = found_ff;
      slot_in   = slot_ff;
      shift_en  = 1'b0;
      req_stall = 1'b1;
      rsp_load  = 1'b0;
      unique case (state_ff)
         slm_pkg::ST_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               state_in = slm_pkg::ST_SCAN;
               cnt_in   = '0;
               found_in = 1'b0;
               slot_in  = '0;
            end
         end
         slm_pkg::ST_SCAN: begin
            shift_en = 1'b1;
            if (hit) begin
               found_in = 1'b1;
               slot_in  = cnt_ff;
            end
            if (cnt_ff == LAST_IDX) begin
               state_in = slm_pkg::ST_POST;
            end else begin
               cnt_in = cnt_ff + 1'b1;
            end
         end
         slm_pkg::ST_POST: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_load = 1'b1;
               state_in = slm_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = slm_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= slm_pkg::ST_IDLE;
         cnt_ff       <= '0;
         found_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         found_ff     <= found_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      slot_ff <= slot_in;
      if (accept) begin
         op_ff  <= req_opcode;
         sid_ff <= req_space_id;
         va_ff  <= req_virt_addr;
      end
   end

   // result formatting
   always_comb begin
      slot_ext    = found_ff ? (IDX_W+8)'(slot_ff) : '0;
      offset_prod = PROD_W'(slot_ext[IDX_W-1:0]) * PAGE_STRIDE;
      case (op_ff)
         slm_pkg::OP_SWAP_OUT: status_res = found_ff ? slm_pkg::STATUS_OK
                                                     : slm_pkg::STATUS_FULL;
         slm_pkg::OP_SWAP_IN:  status_res = found_ff ? slm_pkg::STATUS_OK
                                                     : slm_pkg::STATUS_MISSING;
         default:              status_res = slm_pkg::STATUS_OK;
      endcase
   end

   assign rsp_valid_in = rsp_load || (rsp_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_slot_ff   <= slot_ext[7:0];
         rsp_offset_ff <= offset_prod[slm_pkg::OFFSET_W-1:0];
         rsp_status_ff <= status_res;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_slot_index  = rsp_slot_ff;
   assign rsp_swap_offset = rsp_offset_ff;
   assign rsp_status      = rsp_status_ff;

endmodule

`default_nettype wire

@@ bench/swap_slot_map_top_tb.sv @@
`default_nettype none

module swap_slot_map_top_tb;

   localparam int SLOT_COUNT = 256;
   localparam int PAGE_BYTES = 4096;
   localparam logic [1:0] OP_UNUSED = 2'd3;
   localparam int POOL_SIZE = 8;

   typedef struct packed {
      logic [1:0]                  op;
      logic [slm_pkg::SPACE_W-1:0] sid;
      logic [slm_pkg::VADDR_W-1:0] va;
   } swap_req_type;

   typedef struct packed {
      logic [slm_pkg::INDEX_W-1:0]  slot_index;
      logic [slm_pkg::OFFSET_W-1:0] swap_offset;
      logic [1:0]                   status;
   } swap_rsp_type;

   typedef enum int {
      STALL_NONE,
      STALL_RANDOM,
      STALL_RUNS
   } stall_mode_type;

   logic                         clock = 1'b0;
   logic                         reset = 1'b1;
   logic                         req_valid = 1'b0;
   wire                          req_stall;
   logic [1:0]                   req_opcode = '0;
   logic [slm_pkg::SPACE_W-1:0]  req_space_id = '0;
   logic [slm_pkg::VADDR_W-1:0]  req_virt_addr = '0;
   wire                          rsp_valid;
   logic                         rsp_stall = 1'b0;
   wire [slm_pkg::INDEX_W-1:0]   rsp_slot_index;
   wire [slm_pkg::OFFSET_W-1:0]  rsp_swap_offset;
   wire [1:0]                    rsp_status;

   swap_slot_map_top #(
      .SLOT_COUNT(SLOT_COUNT),
      .PAGE_BYTES(PAGE_BYTES)
   ) u_dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_opcode(req_opcode),
      .req_space_id(req_space_id),
      .req_virt_addr(req_virt_addr),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_slot_index(rsp_slot_index),
      .rsp_swap_offset(rsp_swap_offset),
      .rsp_status(rsp_status)
   );

   always #4 clock = ~clock;

   // predicted slot table
   bit                          tbl_valid [SLOT_COUNT];
   logic [slm_pkg::SPACE_W-1:0] tbl_space [SLOT_COUNT];
   logic [slm_pkg::VADDR_W-1:0] tbl_vaddr [SLOT_COUNT];

   swap_req_type req_pending [$];
   swap_rsp_type rsp_expected [$];
   swap_req_type cur_req;
   int           accepted_count = 0;
   int           total_items = 0;
   int           mismatches = 0;

   // generator view of the table: multiset of live pairs
   logic [slm_pkg::SPACE_W-1:0] live_space [$];
   logic [slm_pkg::VADDR_W-1:0] live_vaddr [$];
   logic [slm_pkg::SPACE_W-1:0] space_pool [POOL_SIZE];

   function automatic swap_rsp_type slot_result(int slot, logic [1:0] status);
      swap_rsp_type r;
      longint       prod;
      prod = longint'(slot) * longint'(PAGE_BYTES);
      r.slot_index  = slot[slm_pkg::INDEX_W-1:0];
      r.swap_offset = prod[slm_pkg::OFFSET_W-1:0];
      r.status      = status;
      return r;
   endfunction

   function automatic swap_rsp_type predict_slot_op(swap_req_type rq);
      if (rq.op == slm_pkg::OP_SWAP_OUT) begin
         for (int i = 0; i < SLOT_COUNT; i++) begin
            if (!tbl_valid[i]) begin
               tbl_valid[i] = 1'b1;
               tbl_space[i] = rq.sid;
               tbl_vaddr[i] = rq.va;
               return slot_result(i, slm_pkg::STATUS_OK);
            end
         end
         return slot_result(0, slm_pkg::STATUS_FULL);
      end
      if (rq.op == slm_pkg::OP_SWAP_IN) begin
         for (int i = 0; i < SLOT_COUNT; i++) begin
            if (tbl_valid[i] && tbl_space[i] == rq.sid
                && tbl_vaddr[i] == rq.va) begin
               tbl_valid[i] = 1'b0;
               return slot_result(i, slm_pkg::STATUS_OK);
            end
         end
         return slot_result(0, slm_pkg::STATUS_MISSING);
      end
      if (rq.op == slm_pkg::OP_CLEAN) begin
         for (int i = 0; i < SLOT_COUNT; i++) begin
            if (tbl_valid[i] && tbl_space[i] == rq.sid) tbl_valid[i] = 1'b0;
         end
      end
      return slot_result(0, slm_pkg::STATUS_OK);
   endfunction

   task automatic queue_req(logic [1:0] op, logic [slm_pkg::SPACE_W-1:0] sid,
                            logic [slm_pkg::VADDR_W-1:0] va);
      swap_req_type rq;
      int           k;
      rq.op = op;
      rq.sid = sid;
      rq.va = va;
      req_pending.push_back(rq);
      total_items++;
      if (op == slm_pkg::OP_SWAP_OUT && live_space.size() < SLOT_COUNT) begin
         live_space.push_back(sid);
         live_vaddr.push_back(va);
      end else if (op == slm_pkg::OP_SWAP_IN) begin
         for (k = 0; k < live_space.size(); k++) begin
            if (live_space[k] == sid && live_vaddr[k] == va) break;
         end
         if (k < live_space.size()) begin
            live_space.delete(k);
            live_vaddr.delete(k);
         end
      end else if (op == slm_pkg::OP_CLEAN) begin
         for (k = live_space.size() - 1; k >= 0; k--) begin
            if (live_space[k] == sid) begin
               live_space.delete(k);
               live_vaddr.delete(k);
            end
         end
      end
   endtask

   function automatic logic [slm_pkg::VADDR_W-1:0] pick_vaddr();
      int r;
      r = $urandom_range(0, 99);
      if (r < 8) return '0;
      if (r < 14) return '1;
      if (r < 30) return slm_pkg::VADDR_W'($urandom_range(0, 7));
      return $urandom;
   endfunction

   task automatic queue_random(int n, int pct_out, int pct_hit, int pct_miss,
                               int pct_clean);
      int                          r;
      int                          k;
      logic [slm_pkg::SPACE_W-1:0] sid;
      for (int j = 0; j < n; j++) begin
         r = $urandom_range(0, 99);
         sid = ($urandom_range(0, 9) == 0) ? slm_pkg::SPACE_W'($urandom) :
               space_pool[$urandom_range(0, POOL_SIZE - 1)];
         if (r < pct_out) begin
            queue_req(slm_pkg::OP_SWAP_OUT, sid, pick_vaddr());
         end else if (r < pct_out + pct_hit) begin
            if (live_space.size() != 0) begin
               k = $urandom_range(0, live_space.size() - 1);
               queue_req(slm_pkg::OP_SWAP_IN, live_space[k], live_vaddr[k]);
            end else begin
               queue_req(slm_pkg::OP_SWAP_IN, sid, pick_vaddr());
            end
         end else if (r < pct_out + pct_hit + pct_miss) begin
            queue_req(slm_pkg::OP_SWAP_IN, sid, pick_vaddr());
         end else if (r < pct_out + pct_hit + pct_miss + pct_clean) begin
            queue_req(slm_pkg::OP_CLEAN, sid, $urandom);
         end else begin
            queue_req(OP_UNUSED, slm_pkg::SPACE_W'($urandom), $urandom);
         end
      end
   endtask

   initial begin
      space_pool[0] = '0;
      space_pool[1] = '1;
      for (int i = 2; i < POOL_SIZE; i++) space_pool[i] = slm_pkg::SPACE_W'($urandom);

      // directed
      queue_req(slm_pkg::OP_SWAP_IN, 8'h00, 32'h0000_0000);    // empty table
      queue_req(slm_pkg::OP_SWAP_OUT, 8'h00, 32'h0000_0000);   // address zero kept
      queue_req(slm_pkg::OP_SWAP_OUT, 8'hff, 32'hffff_ffff);
      queue_req(slm_pkg::OP_SWAP_OUT, 8'hff, 32'h0000_0000);
      queue_req(slm_pkg::OP_SWAP_IN, 8'h00, 32'h0000_0000);
      queue_req(slm_pkg::OP_SWAP_IN, 8'h00, 32'h0000_0000);    // already freed
      queue_req(slm_pkg::OP_SWAP_OUT, 8'h00, 32'h1234_5678);   // lowest free reused
      queue_req(slm_pkg::OP_SWAP_IN, 8'h00, 32'hffff_ffff);    // space mismatch
      queue_req(slm_pkg::OP_SWAP_IN, 8'hfe, 32'h1234_5678);
      queue_req(OP_UNUSED, 8'hff, 32'hffff_ffff);
      queue_req(OP_UNUSED, 8'h00, 32'h0000_0000);
      queue_req(slm_pkg::OP_CLEAN, 8'hff, 32'hffff_ffff);
      queue_req(slm_pkg::OP_SWAP_IN, 8'hff, 32'hffff_ffff);    // cleaned away
      queue_req(slm_pkg::OP_CLEAN, 8'h07, 32'h0000_0000);      // nothing owned
      queue_req(slm_pkg::OP_SWAP_OUT, 8'h01, 32'h0000_0005);
      queue_req(slm_pkg::OP_SWAP_OUT, 8'h01, 32'h0000_0005);   // duplicate pair
      queue_req(slm_pkg::OP_SWAP_IN, 8'h01, 32'h0000_0005);
      queue_req(slm_pkg::OP_SWAP_IN, 8'h01, 32'h0000_0005);
      queue_req(slm_pkg::OP_SWAP_IN, 8'h01, 32'h0000_0005);
      queue_req(slm_pkg::OP_SWAP_OUT, 8'haa, 32'h5555_aaaa);
      queue_req(slm_pkg::OP_CLEAN, 8'h00, 32'h0000_0000);
      queue_req(slm_pkg::OP_CLEAN, 8'haa, 32'h0000_0000);

      // fill to full and hammer the full table, then mixed, then refill
      queue_random(400, 90, 6, 1, 1);
      queue_random(1000, 40, 35, 10, 12);
      queue_random(300, 85, 8, 2, 3);

      repeat (3) @(posedge clock);
      reset <= 1'b0;

      while (accepted_count != total_items) @(posedge clock);
      while (rsp_expected.size() != 0) @(posedge clock);
      repeat (SLOT_COUNT + 20) @(posedge clock);
      if (mismatches == 0 && rsp_expected.size() == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

   initial begin
      #40_000_000;
      $display("Mismatches found");
      $finish;
   end

   // driver
   int burst_left = 1;
   int gap_left = 0;

   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         for (int i = 0; i < SLOT_COUNT; i++) tbl_valid[i] = 1'b0;
      end else begin
         if (req_valid && !req_stall) begin
            rsp_expected.push_back(predict_slot_op(cur_req));
            accepted_count++;
         end
         if (!req_valid || !req_stall) begin
            if (gap_left > 0) begin
               gap_left--;
               req_valid <= 1'b0;
            end else if (req_pending.size() != 0) begin
               cur_req = req_pending.pop_front();
               req_valid <= 1'b1;
               req_opcode <= cur_req.op;
               req_space_id <= cur_req.sid;
               req_virt_addr <= cur_req.va;
               burst_left--;
               if (burst_left <= 0) begin
                  burst_left = $urandom_range(1, 8);
                  case ($urandom_range(0, 19))
                     0: gap_left = $urandom_range(100, 400);
                     1, 2, 3, 4, 5, 6, 7, 8, 9, 10: gap_left = $urandom_range(1, 12);
                     default: gap_left = 0;
                  endcase
               end
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // monitor
   stall_mode_type stall_mode = STALL_NONE;
   int             mode_left = 0;
   int             run_left = 0;
   bit             stall_level = 1'b0;
   swap_rsp_type   want;

   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (rsp_expected.size() == 0) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("unexpected beat: slot %0d offset %0d status %0d",
                           rsp_slot_index, rsp_swap_offset, rsp_status);
            end else begin
               want = rsp_expected.pop_front();
               if (rsp_slot_index !== want.slot_index
                   || rsp_swap_offset !== want.swap_offset
                   || rsp_status !== want.status) begin
                  mismatches++;
                  if (mismatches <= 10)
                     $display({"beat mismatch: expected slot %0d offset %0d status %0d,",
                               " got slot %0d offset %0d status %0d"},
                              want.slot_index, want.swap_offset, want.status,
                              rsp_slot_index, rsp_swap_offset, rsp_status);
               end
            end
         end
         if (mode_left == 0) begin
            mode_left = $urandom_range(64, 512);
            case ($urandom_range(0, 2))
               0: stall_mode = STALL_NONE;
               1: stall_mode = STALL_RANDOM;
               default: stall_mode = STALL_RUNS;
            endcase
         end else begin
            mode_left--;
         end
         case (stall_mode)
            STALL_NONE: rsp_stall <= 1'b0;
            STALL_RANDOM: rsp_stall <= ($urandom_range(0, 2) == 0);
            default: begin
               if (run_left > 0) begin
                  run_left--;
               end else begin
                  stall_level = ~stall_level;
                  run_left = stall_level ? $urandom_range(1, 300) : $urandom_range(1, 20);
               end
               rsp_stall <= stall_level;
            end
         endcase
      end
   end

endmodule

`default_nettype wire

@@ filelist.f @@
src/slm_pkg.sv
src/slm_cell.sv
src/swap_slot_map_top.sv
bench/swap_slot_map_top_tb.sv
